// File: rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Shared constants, codes, transaction types and the CRC16 byte update.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int MaxPayloadDefault = 32;
  localparam int RouteCountDefault = 2;

  // Largest payload any configuration may use, and the widths that follow.
  localparam int MaxPayloadLimit = 64;
  localparam int LenW            = $clog2(MaxPayloadLimit + 1);
  localparam int AddrW           = $clog2(MaxPayloadLimit);

  localparam int CmdDepth = 2;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcMsb  = 16'h8000;

  typedef enum logic [2:0] {
    ST_PAYLOAD     = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_BAD_LENGTH  = 3'd2,
    ST_CRC_ERROR   = 3'd3,
    ST_UNKNOWN_ID  = 3'd4,
    ST_ROUTE_LEN   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CFG_MAGIC_FIRST    = 3'd0,
    CFG_MAGIC_SECOND   = 3'd1,
    CFG_VERSION        = 3'd2,
    CFG_ROUTE0_ID      = 3'd3,
    CFG_ROUTE0_LENGTH  = 3'd4,
    CFG_ROUTE1_ID      = 3'd5,
    CFG_ROUTE1_LENGTH  = 3'd6
  } cfg_index_e;

  // One decision of the parser: either a single error result or a payload run.
  typedef struct packed {
    logic            is_run;
    status_e         status;
    logic [7:0]      id;
    logic            route;
    logic [LenW-1:0] len;
  } cmd_t;

  // Payload buffer write port.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/framed_packet_receiver_crc16.sv
// ----------------------------------------------------------------------------
// Framed packet receiver with CRC16 check
// Byte-serial frame parser with route matching and a queued result port.
// ----------------------------------------------------------------------------
// The receiver takes one byte per clock while it parses sync, header and
// payload, as long as the two-entry command queue between parser and result
// sequencer has room; when results are not taken and that queue fills, every
// input byte waits. A frame that fails a check gives one error result, queued
// behind at most two pending decisions. A good frame of N payload bytes is
// replayed from the internal payload buffer as N results; each byte is a
// registered buffer read followed by a load of the output register, and the
// next read starts only after that load. While that replay runs, header bytes
// of the next frame are still taken; its first payload byte waits until the
// replay has issued its last result. The configuration port never stalls.
module framed_packet_receiver_crc16 import fpr_pkg::*; #(
  parameter int MAX_PAYLOAD = MaxPayloadDefault,
  parameter int ROUTE_COUNT = RouteCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] status_o,
  output logic [7:0] message_id_o,
  output logic       route_index_o,
  output logic [4:0] byte_index_o,
  output logic [7:0] payload_byte_o,
  output logic       last_o
);

  cmd_t cmd_in, cmd_out;
  wr_t  wr;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic run_done;

  assign cfg_ready_o = 1'b1;

  fpr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .ROUTE_COUNT (ROUTE_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .rx_byte_i   (rx_byte_i),
    .full_o      (full),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .wr_o        (wr),
    .run_done_i  (run_done)
  );

  fpr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  fpr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_empty_i    (cmd_empty),
    .cmd_i          (cmd_out),
    .cmd_pop_o      (cmd_pop),
    .wr_i           (wr),
    .run_done_o     (run_done),
    .pop_i          (pop),
    .empty_o        (empty),
    .status_o       (status_o),
    .message_id_o   (message_id_o),
    .route_index_o  (route_index_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o)
  );

endmodule

// File: rtl/fpr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short queue that decouples the byte parser from the result sequencer.
// ----------------------------------------------------------------------------
module fpr_cmd_fifo import fpr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;

  cmd_t            entry_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (PtrW + 1)'(CmdDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/fpr_front.sv
// ----------------------------------------------------------------------------
// Frame parser
// Holds the configuration, hunts for sync, checks header and CRC, writes the
// payload into the buffer and queues one command per frame outcome.
// ----------------------------------------------------------------------------
module fpr_front import fpr_pkg::*; #(
  parameter int MAX_PAYLOAD = MaxPayloadDefault,
  parameter int ROUTE_COUNT = RouteCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push_i,
  input  logic [7:0] rx_byte_i,
  output logic       full_o,
  input  logic       cmd_full_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o,
  output wr_t        wr_o,
  input  logic       run_done_i
);

  typedef enum logic [7:0] {
    PH_MAGIC0  = 8'b0000_0001,
    PH_MAGIC1  = 8'b0000_0010,
    PH_VERSION = 8'b0000_0100,
    PH_ID      = 8'b0000_1000,
    PH_LENGTH  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CRC0    = 8'b0100_0000,
    PH_CRC1    = 8'b1000_0000
  } phase_e;

  localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD);

  logic [7:0] magic_first_q, magic_second_q, version_q;
  logic [7:0] route0_id_q, route1_id_q;
  logic [5:0] route0_len_q, route1_len_q;

  phase_e          phase_q, phase_d;
  logic [7:0]      id_q, id_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] count_q, count_d;
  logic [7:0]      crc_low_q, crc_low_d;
  logic [15:0]     crc_q, crc_d;
  logic            run_busy_q, run_busy_d;

  logic        accept;
  logic        hit0, hit1;
  logic [15:0] crc_next;

  // A new payload may not overwrite the buffer while the previous run drains.
  assign full_o   = cmd_full_i || ((phase_q == PH_PAYLOAD) && run_busy_q);
  assign accept   = push_i && !full_o;
  assign crc_next = crc_add(crc_q, rx_byte_i);
  assign hit0     = (id_q == route0_id_q);
  assign hit1     = (ROUTE_COUNT >= 2) && (id_q == route1_id_q);

  always_comb begin
    phase_d    = phase_q;
    id_d       = id_q;
    len_d      = len_q;
    count_d    = count_q;
    crc_low_d  = crc_low_q;
    crc_d      = crc_q;
    run_busy_d = run_busy_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{is_run: 1'b0, status: ST_PAYLOAD, id: id_q, route: 1'b0, len: len_q};
    wr_o       = '{en: 1'b0, addr: count_q[AddrW-1:0], data: rx_byte_i};

    if (run_done_i) begin
      run_busy_d = 1'b0;
    end

    if (accept) begin
      case (phase_q)
        PH_MAGIC0: begin
          if (rx_byte_i == magic_first_q) begin
            phase_d = PH_MAGIC1;
          end
        end
        PH_MAGIC1: begin
          phase_d = (rx_byte_i == magic_second_q) ? PH_VERSION : PH_MAGIC0;
        end
        PH_VERSION: begin
          if (rx_byte_i != version_q) begin
            cmd_push_o   = 1'b1;
            cmd_o.status = ST_BAD_VERSION;
            cmd_o.id     = 8'h00;
            phase_d      = PH_MAGIC0;
          end else begin
            crc_d   = crc_add(CrcInit, rx_byte_i);
            phase_d = PH_ID;
          end
        end
        PH_ID: begin
          id_d    = rx_byte_i;
          crc_d   = crc_next;
          phase_d = PH_LENGTH;
        end
        PH_LENGTH: begin
          if ((rx_byte_i == 8'h00) || ({1'b0, rx_byte_i} > MaxLen)) begin
            cmd_push_o   = 1'b1;
            cmd_o.status = ST_BAD_LENGTH;
            phase_d      = PH_MAGIC0;
          end else begin
            len_d   = LenW'(rx_byte_i);
            count_d = '0;
            crc_d   = crc_next;
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          wr_o.en = 1'b1;
          count_d = count_q + 1'b1;
          crc_d   = crc_next;
          if (count_d == len_q) begin
            phase_d = PH_CRC0;
          end
        end
        PH_CRC0: begin
          crc_low_d = rx_byte_i;
          phase_d   = PH_CRC1;
        end
        PH_CRC1: begin
          cmd_push_o = 1'b1;
          phase_d    = PH_MAGIC0;
          if ({rx_byte_i, crc_low_q} != crc_q) begin
            cmd_o.status = ST_CRC_ERROR;
          end else if (hit0) begin
            if (LenW'(route0_len_q) != len_q) begin
              cmd_o.status = ST_ROUTE_LEN;
            end else begin
              cmd_o.is_run = 1'b1;
              run_busy_d   = 1'b1;
            end
          end else if (hit1) begin
            cmd_o.route = 1'b1;
            if (LenW'(route1_len_q) != len_q) begin
              cmd_o.status = ST_ROUTE_LEN;
            end else begin
              cmd_o.is_run = 1'b1;
              run_busy_d   = 1'b1;
            end
          end else begin
            cmd_o.status = ST_UNKNOWN_ID;
          end
        end
        default: begin
          phase_d = PH_MAGIC0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC0;
      id_q       <= '0;
      len_q      <= '0;
      count_q    <= '0;
      crc_low_q  <= '0;
      crc_q      <= CrcInit;
      run_busy_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      id_q       <= id_d;
      len_q      <= len_d;
      count_q    <= count_d;
      crc_low_q  <= crc_low_d;
      crc_q      <= crc_d;
      run_busy_q <= run_busy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_first_q  <= 8'hAA;
      magic_second_q <= 8'h55;
      version_q      <= 8'h01;
      route0_id_q    <= 8'h01;
      route0_len_q   <= 6'd8;
      route1_id_q    <= 8'h02;
      route1_len_q   <= 6'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAGIC_FIRST:   magic_first_q  <= cfg_data_i;
        CFG_MAGIC_SECOND:  magic_second_q <= cfg_data_i;
        CFG_VERSION:       version_q      <= cfg_data_i;
        CFG_ROUTE0_ID:     route0_id_q    <= cfg_data_i;
        CFG_ROUTE0_LENGTH: route0_len_q   <= cfg_data_i[5:0];
        CFG_ROUTE1_ID:     route1_id_q    <= cfg_data_i;
        CFG_ROUTE1_LENGTH: route1_len_q   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/fpr_back.sv
// ----------------------------------------------------------------------------
// Result sequencer
// Owns the payload buffer, turns queued commands into results and holds the
// oldest result in an output register until it is taken.
// ----------------------------------------------------------------------------
module fpr_back import fpr_pkg::*; #(
  parameter int MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_empty_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  input  wr_t        wr_i,
  output logic       run_done_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [2:0] status_o,
  output logic [7:0] message_id_o,
  output logic       route_index_o,
  output logic [4:0] byte_index_o,
  output logic [7:0] payload_byte_o,
  output logic       last_o
);

  localparam int IdxW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } seq_e;

  logic [7:0] mem_q [MAX_PAYLOAD];
  logic [7:0] rd_data_q;

  seq_e            state_q, state_d;
  logic [7:0]      id_q, id_d;
  logic            route_q, route_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [LenW-1:0] idx_inc;

  logic       out_valid_q, out_valid_d;
  status_e    out_status_q, out_status_d;
  logic [7:0] out_id_q, out_id_d;
  logic       out_route_q, out_route_d;
  logic [4:0] out_index_q, out_index_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_free, out_load;

  assign out_free = !out_valid_q || pop_i;
  assign idx_inc  = idx_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[IdxW-1:0]] <= wr_i.data;
    end
    rd_data_q <= mem_q[idx_q[IdxW-1:0]];
  end

  always_comb begin
    state_d      = state_q;
    id_d         = id_q;
    route_d      = route_q;
    len_d        = len_q;
    idx_d        = idx_q;
    cmd_pop_o    = 1'b0;
    run_done_o   = 1'b0;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_route_d  = out_route_q;
    out_index_d  = out_index_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i && out_free) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.is_run) begin
            id_d    = cmd_i.id;
            route_d = cmd_i.route;
            len_d   = cmd_i.len;
            idx_d   = '0;
            state_d = S_READ;
          end else begin
            out_load     = 1'b1;
            out_status_d = cmd_i.status;
            out_id_d     = cmd_i.id;
            out_route_d  = cmd_i.route;
            out_index_d  = '0;
            out_byte_d   = '0;
            out_last_d   = 1'b1;
          end
        end
      end
      S_READ: begin
        // The buffer read issued from idx_q lands in rd_data_q this cycle.
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ST_PAYLOAD;
          out_id_d     = id_q;
          out_route_d  = route_q;
          out_index_d  = idx_q[4:0];
          out_byte_d   = rd_data_q;
          out_last_d   = (idx_inc == len_q);
          if (idx_inc == len_q) begin
            run_done_o = 1'b1;
            state_d    = S_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    route_q      <= route_d;
    len_q        <= len_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_route_q  <= out_route_d;
    out_index_q  <= out_index_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
  end

  assign empty_o        = !out_valid_q;
  assign status_o       = out_status_q;
  assign message_id_o   = out_id_q;
  assign route_index_o  = out_route_q;
  assign byte_index_o   = out_index_q;
  assign payload_byte_o = out_byte_q;
  assign last_o         = out_last_q;

endmodule

// File: tb/sv/tb_framed_packet_receiver_crc16.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Sends sync-framed byte streams through the receiver. The streams are good
// frames, each kind of broken frame, and line noise, under several register
// settings and with random gaps and stalls on both sides. Every popped result
// is checked against a cycle-free model of the parser that is kept in step
// with each accepted byte.
// ----------------------------------------------------------------------------
module tb_framed_packet_receiver_crc16;
  import fpr_pkg::*;

  localparam int ClkHalf       = 10;
  localparam int ResetCycles   = 11;
  localparam int SettleCycles  = 16;
  localparam int HoldOffCycles = 400;

  typedef enum logic [7:0] {
    PH_HUNT_FIRST  = 8'b0000_0001,
    PH_HUNT_SECOND = 8'b0000_0010,
    PH_VERSION     = 8'b0000_0100,
    PH_ID          = 8'b0000_1000,
    PH_LENGTH      = 8'b0001_0000,
    PH_PAYLOAD     = 8'b0010_0000,
    PH_CRC_LOW     = 8'b0100_0000,
    PH_CRC_HIGH    = 8'b1000_0000
  } parse_phase_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] id;
    logic       route;
    logic [4:0] pos;
    logic [7:0] data;
    logic       last;
  } rx_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       push;
  logic       full;
  logic [7:0] rx_byte_i;
  logic       empty;
  logic       pop;
  logic [2:0] status_o;
  logic [7:0] message_id_o;
  logic       route_index_o;
  logic [4:0] byte_index_o;
  logic [7:0] payload_byte_o;
  logic       last_o;

  // Parser model state and its copy of the registers.
  parse_phase_e parse_phase;
  logic [7:0]   cfg_regs [7];
  logic [7:0]   held_id;
  logic [5:0]   held_len;
  logic [5:0]   payload_count;
  logic [7:0]   crc_low;
  logic [15:0]  running_crc;
  logic [7:0]   payload_store [MaxPayloadDefault];
  rx_result_t   expected_results [$];

  int bytes_sent        = 0;
  int results_checked   = 0;
  int good_frames       = 0;
  int error_results     = 0;
  int mismatches        = 0;
  int settings_loaded   = 0;
  int full_cycles       = 0;
  int stall_cycles      = 0;
  bit no_idle           = 1'b0;

  framed_packet_receiver_crc16 u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .message_id_o  (message_id_o),
    .route_index_o (route_index_o),
    .byte_index_o  (byte_index_o),
    .payload_byte_o(payload_byte_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // CRC16-CCITT, one data bit at a time, MSB first.
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  function automatic void expect_error(input status_e st, input logic [7:0] id,
                                       input logic route);
    rx_result_t r;
    r.status = st;
    r.id     = id;
    r.route  = route;
    r.pos    = 5'd0;
    r.data   = 8'h00;
    r.last   = 1'b1;
    expected_results.push_back(r);
    error_results++;
  endfunction

  // Advances the parser model by one accepted byte and queues what it yields.
  function automatic void predict_byte(input logic [7:0] b);
    rx_result_t r;
    logic [5:0] need;
    logic       route;
    logic       routed;
    need   = '0;
    route  = 1'b0;
    routed = 1'b1;
    case (parse_phase)
      PH_HUNT_FIRST: begin
        if (b == cfg_regs[CFG_MAGIC_FIRST]) parse_phase = PH_HUNT_SECOND;
      end
      PH_HUNT_SECOND: begin
        // A wrong second byte is dropped, never taken as a new first magic.
        parse_phase = (b == cfg_regs[CFG_MAGIC_SECOND]) ? PH_VERSION : PH_HUNT_FIRST;
      end
      PH_VERSION: begin
        if (b != cfg_regs[CFG_VERSION]) begin
          expect_error(ST_BAD_VERSION, 8'h00, 1'b0);
          parse_phase = PH_HUNT_FIRST;
        end else begin
          running_crc = crc16_next(CrcInit, b);
          parse_phase = PH_ID;
        end
      end
      PH_ID: begin
        held_id     = b;
        running_crc = crc16_next(running_crc, b);
        parse_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (b == 8'd0 || b > MaxPayloadDefault) begin
          expect_error(ST_BAD_LENGTH, held_id, 1'b0);
          parse_phase = PH_HUNT_FIRST;
        end else begin
          held_len      = b[5:0];
          payload_count = '0;
          running_crc   = crc16_next(running_crc, b);
          parse_phase   = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        payload_store[payload_count[4:0]] = b;
        payload_count++;
        running_crc = crc16_next(running_crc, b);
        if (payload_count >= held_len) parse_phase = PH_CRC_LOW;
      end
      PH_CRC_LOW: begin
        crc_low     = b;
        parse_phase = PH_CRC_HIGH;
      end
      default: begin
        parse_phase = PH_HUNT_FIRST;
        if ({b, crc_low} != running_crc) begin
          expect_error(ST_CRC_ERROR, held_id, 1'b0);
        end else begin
          // Route zero is tried first, so it wins when both share an id.
          if (held_id == cfg_regs[CFG_ROUTE0_ID]) begin
            need = cfg_regs[CFG_ROUTE0_LENGTH][5:0];
          end else if (held_id == cfg_regs[CFG_ROUTE1_ID]) begin
            route = 1'b1;
            need  = cfg_regs[CFG_ROUTE1_LENGTH][5:0];
          end else begin
            routed = 1'b0;
          end
          if (!routed) begin
            expect_error(ST_UNKNOWN_ID, held_id, 1'b0);
          end else if (need != held_len) begin
            expect_error(ST_ROUTE_LEN, held_id, route);
          end else begin
            good_frames++;
            for (int i = 0; i < held_len; i++) begin
              r.status = ST_PAYLOAD;
              r.id     = held_id;
              r.route  = route;
              r.pos    = i[4:0];
              r.data   = payload_store[i[4:0]];
              r.last   = (i == held_len - 1);
              expected_results.push_back(r);
            end
          end
        end
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    rx_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t ns: result with nothing expected, actual status %0d id %0h byte %0h",
               $time, status_o, message_id_o, payload_byte_o);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      compare_field("status", 8'(want.status), 8'(status_o));
      compare_field("message_id", want.id, message_id_o);
      compare_field("route_index", 8'(want.route), 8'(route_index_o));
      compare_field("byte_index", 8'(want.pos), 8'(byte_index_o));
      compare_field("payload_byte", want.data, payload_byte_o);
      compare_field("last", 8'(want.last), 8'(last_o));
    end
  endfunction

  // Result side: one transaction per edge with pop high and empty low.
  initial begin : result_sink
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_result();
      if (stall_cycles > 0) begin
        stall_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(99) >= 10);
      end
    end
  end

  // Leaves push high so that back-to-back bytes need no extra edge.
  task automatic send_byte(input logic [7:0] b);
    if (!no_idle && $urandom_range(99) < 10) begin
      push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) begin
      full_cycles++;
      @(posedge clk_i);
    end
    bytes_sent++;
    predict_byte(b);
  endtask

  task automatic wait_results_drained();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [7:0] magic_a, magic_b, version, id0, len0,
                               id1, len1);
    logic [7:0] vals [7];
    vals[CFG_MAGIC_FIRST]   = magic_a;
    vals[CFG_MAGIC_SECOND]  = magic_b;
    vals[CFG_VERSION]       = version;
    vals[CFG_ROUTE0_ID]     = id0;
    vals[CFG_ROUTE0_LENGTH] = len0;
    vals[CFG_ROUTE1_ID]     = id1;
    vals[CFG_ROUTE1_LENGTH] = len1;
    for (int i = 0; i < 7; i++) begin
      cfg_index_i <= cfg_index_e'(i);
      cfg_data_i  <= vals[i[2:0]];
      cfg_valid_i <= 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      cfg_regs[i[2:0]] = (i == CFG_ROUTE0_LENGTH || i == CFG_ROUTE1_LENGTH) ?
                         {2'b00, vals[i[2:0]][5:0]} : vals[i[2:0]];
    end
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  // Stops after the version or length byte when the parser will reject it.
  task automatic send_frame(input logic [7:0] version, id, len_byte,
                            input logic [15:0] crc_flip, input bit pattern_body);
    logic [15:0] crc;
    logic [7:0]  data;
    send_byte(cfg_regs[CFG_MAGIC_FIRST]);
    send_byte(cfg_regs[CFG_MAGIC_SECOND]);
    send_byte(version);
    if (version != cfg_regs[CFG_VERSION]) return;
    send_byte(id);
    send_byte(len_byte);
    if (len_byte == 8'd0 || len_byte > MaxPayloadDefault) return;
    crc = crc16_next(crc16_next(crc16_next(CrcInit, version), id), len_byte);
    for (int i = 0; i < len_byte; i++) begin
      data = pattern_body ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(255));
      crc  = crc16_next(crc, data);
      send_byte(data);
    end
    crc = crc ^ crc_flip;
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  task automatic send_random_frame();
    int         pick;
    logic       rt;
    logic [7:0] ver;
    logic [7:0] id;
    logic [5:0] need;
    logic [7:0] len;
    pick = $urandom_range(99);
    rt   = 1'($urandom_range(1));
    ver  = cfg_regs[CFG_VERSION];
    id   = rt ? cfg_regs[CFG_ROUTE1_ID] : cfg_regs[CFG_ROUTE0_ID];
    need = rt ? cfg_regs[CFG_ROUTE1_LENGTH][5:0] : cfg_regs[CFG_ROUTE0_LENGTH][5:0];
    // A route length register out of range can never be met; keep those short.
    len  = (need >= 1 && need <= MaxPayloadDefault) ? {2'b00, need} :
           8'($urandom_range(4, 1));
    if (pick < 60) begin
      send_frame(ver, id, len, 16'h0000, 1'b0);
    end else if (pick < 70) begin
      send_frame(ver, id, len, 16'h0001 << $urandom_range(15), 1'b0);
    end else if (pick < 75) begin
      send_frame(ver ^ (8'h01 << $urandom_range(7)), id, len, 16'h0000, 1'b0);
    end else if (pick < 80) begin
      send_frame(ver, id, ($urandom_range(1) != 0) ? 8'h00 : 8'($urandom_range(255, 33)),
                 16'h0000, 1'b0);
    end else if (pick < 88) begin
      do id = 8'($urandom_range(255));
      while (id == cfg_regs[CFG_ROUTE0_ID] || id == cfg_regs[CFG_ROUTE1_ID]);
      send_frame(ver, id, 8'($urandom_range(4, 1)), 16'h0000, 1'b0);
    end else if (pick < 94) begin
      send_frame(ver, id, 8'((len % MaxPayloadDefault) + 1), 16'h0000, 1'b0);
    end else begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_directed_frames();
    send_frame(8'h00, 8'h01, 8'd8, 16'h0000, 1'b0);
    send_frame(8'h01, 8'hFF, 8'd0, 16'h0000, 1'b0);
    send_frame(8'h01, 8'h01, 8'd33, 16'h0000, 1'b0);
    // Two first magics in a row lose sync; the frame after must still parse.
    send_byte(cfg_regs[CFG_MAGIC_FIRST]);
    send_byte(cfg_regs[CFG_MAGIC_FIRST]);
    send_byte(cfg_regs[CFG_MAGIC_SECOND]);
    send_frame(8'h01, 8'h01, 8'd8, 16'h0000, 1'b1);
    send_frame(8'h01, 8'h01, 8'd1, 16'h8001, 1'b0);
    send_frame(8'h01, 8'h00, 8'd1, 16'h0000, 1'b0);
    send_frame(8'h01, 8'h02, 8'd1, 16'h0000, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_config_sweep();
    load_settings(8'h00, 8'hFF, 8'hFF, 8'h00, 8'd1, 8'hFF, 8'd32);
    // A frame of the largest payload on route one.
    send_frame(8'hFF, 8'hFF, 8'd32, 16'h0000, 1'b0);
    wait_results_drained();
    load_settings(8'hFF, 8'h00, 8'h00, 8'hFF, 8'd32, 8'h00, 8'd1);
    send_frame(8'h00, 8'h00, 8'd1, 16'h0000, 1'b0);
    wait_results_drained();
    // Both routes claim one id, so frames sized for route one are rejected.
    load_settings(8'h5A, 8'hA5, 8'h07, 8'h33, 8'd2, 8'h33, 8'd5);
    send_frame(8'h07, 8'h33, 8'd5, 16'h0000, 1'b0);
    send_frame(8'h07, 8'h33, 8'd2, 16'h0000, 1'b0);
    wait_results_drained();
    load_settings(8'hC3, 8'h3C, 8'h03, 8'h44, 8'd0, 8'h45, 8'd40);
    send_random_frame();
    wait_results_drained();
  endtask

  task automatic test_output_holdoff();
    stall_cycles = HoldOffCycles;
    repeat (2) begin
      send_frame(cfg_regs[CFG_VERSION], cfg_regs[CFG_ROUTE0_ID], cfg_regs[CFG_ROUTE0_LENGTH],
                 16'h0000, 1'b0);
    end
    wait_results_drained();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (3) send_random_frame();
    wait_results_drained();
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_MAGIC_FIRST;
    cfg_data_i  <= 8'h00;
    push        <= 1'b0;
    rx_byte_i   <= 8'h00;
    rst_ni      <= 1'b0;
    cfg_regs[CFG_MAGIC_FIRST]   = 8'hAA;
    cfg_regs[CFG_MAGIC_SECOND]  = 8'h55;
    cfg_regs[CFG_VERSION]       = 8'h01;
    cfg_regs[CFG_ROUTE0_ID]     = 8'h01;
    cfg_regs[CFG_ROUTE0_LENGTH] = 8'd8;
    cfg_regs[CFG_ROUTE1_ID]     = 8'h02;
    cfg_regs[CFG_ROUTE1_LENGTH] = 8'd8;
    parse_phase   = PH_HUNT_FIRST;
    held_id       = '0;
    held_len      = '0;
    payload_count = '0;
    crc_low       = '0;
    running_crc   = CrcInit;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_config_sweep();
    load_settings(8'h7E, 8'h81, 8'h02, 8'h10, 8'd4, 8'h20, 8'd3);
    test_output_holdoff();
    test_back_to_back();

    $display("Checked %0d results from %0d received bytes under %0d register settings.",
             results_checked, bytes_sent, settings_loaded + 1);
    $display("%0d good frames, %0d error results, input held off for %0d cycles.",
             good_frames, error_results, full_cycles);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/fpr_pkg.sv
rtl/fpr_cmd_fifo.sv
rtl/fpr_front.sv
rtl/fpr_back.sv
rtl/framed_packet_receiver_crc16.sv
tb/sv/tb_framed_packet_receiver_crc16.sv
